FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module.
// Expects aclk and aresetn in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define BTMX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BTMX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/btmx_pkg.sv
// Types and constants for the binary trie max-xor block.
// No dependencies.
`default_nettype none
package btmx_pkg;
    localparam int KEY_BITS   = 60;
    localparam int NODE_COUNT = 4096;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = NODE_W + 1;
    localparam int LINK_W     = 2 * NODE_W;
    localparam int CNT_W      = 32;
    localparam int IN_DATA_W  = ((KEY_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((KEY_BITS + CNT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_QUERY,
        OP_SKIP
    } op_t;

    typedef struct packed {
        logic                act;
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        logic [NODE_W-1:0]   node;
        logic                fresh;
        logic [KEY_BITS-1:0] res;
    } hop_t;
endpackage
`default_nettype wire

FILE: rtl/binary_trie_max_xor.sv
// Binary trie with maximum-xor query: top level, a chain of one cell per key bit.
// Depends on btmx_pkg and btmx_cell.
// A word walks one trie level per cycle through the cells, then the output register.
// A new word is taken only after the last result has been taken; one item in flight.
// Reset (aresetn low, synchronous): trie empty, root count zero, next free node one.
// No clearing pass: fresh nodes read as empty through a flag carried down the chain.
`default_nettype none
module binary_trie_max_xor (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [btmx_pkg::IN_DATA_W-1:0]     s_tdata,  // key_value
    input  wire logic [0:0]                         s_tuser,  // operation
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [btmx_pkg::OUT_DATA_W-1:0]    m_tdata,  // max_xor, stored_count
    output logic      [0:0]                         m_tuser   // rejected
);
    localparam int KB = btmx_pkg::KEY_BITS;

    btmx_pkg::hop_t                  chain [KB+1];
    logic [KB-1:0]                   alloc_vec;
    logic [btmx_pkg::FREE_W-1:0]     free_reg;
    logic [btmx_pkg::CNT_W-1:0]      root_cnt_reg;
    logic                            busy_reg, out_valid_reg, rej_reg;
    logic [KB-1:0]                   xor_reg;
    logic                            s_acc, m_acc, full, is_insert;

    assign s_tready  = !busy_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign is_insert = (s_tuser[0] == 1'b0);
    assign full      = free_reg > btmx_pkg::FREE_W'(btmx_pkg::NODE_COUNT - KB);

    always_comb begin
        chain[0].act   = s_acc;
        chain[0].key   = s_tdata[KB-1:0];
        chain[0].node  = '0;
        chain[0].fresh = (root_cnt_reg == '0);
        chain[0].res   = '0;
        if (is_insert) begin
            chain[0].op = full ? btmx_pkg::OP_SKIP : btmx_pkg::OP_INSERT;
        end else begin
            chain[0].op = (root_cnt_reg == '0) ? btmx_pkg::OP_SKIP : btmx_pkg::OP_QUERY;
        end
    end

    for (genvar i = 0; i < KB; i++) begin : g_cell
        btmx_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .hop_in    (chain[i]),
            .next_free (free_reg),
            .hop_out   (chain[i+1]),
            .alloc     (alloc_vec[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg      <= btmx_pkg::FREE_W'(1);
            root_cnt_reg  <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rej_reg       <= 1'b0;
        end else begin
            if (|alloc_vec) begin
                free_reg <= free_reg + 1'b1;
            end
            if (s_acc) begin
                busy_reg <= 1'b1;
                rej_reg  <= is_insert && full;
                if (is_insert && !full && root_cnt_reg != '1) begin
                    root_cnt_reg <= root_cnt_reg + 1'b1;
                end
            end
            if (chain[KB].act) begin
                out_valid_reg <= 1'b1;
            end else if (m_acc) begin
                out_valid_reg <= 1'b0;
                busy_reg      <= 1'b0;
            end
        end
        if (chain[KB].act) begin
            xor_reg <= (chain[KB].op == btmx_pkg::OP_QUERY) ? chain[KB].res : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = rej_reg;
    assign m_tdata  = {{(btmx_pkg::OUT_DATA_W - KB - btmx_pkg::CNT_W){1'b0}},
                       root_cnt_reg, xor_reg};
endmodule
`default_nettype wire

FILE: rtl/btmx_ram.sv
// Generic simple dual-port RAM, registered read.
// No dependencies.
`default_nettype none
module btmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/btmx_cell.sv
// One trie level: link table for the nodes at this depth and the walk step.
// Depends on btmx_pkg and btmx_ram.
`default_nettype none
module btmx_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire btmx_pkg::hop_t                hop_in,
    input  wire logic [btmx_pkg::FREE_W-1:0]   next_free,
    output btmx_pkg::hop_t                     hop_out,
    output logic                               alloc
);
    btmx_pkg::hop_t                  stage_reg;
    logic [btmx_pkg::LINK_W-1:0]     rdata;
    logic [btmx_pkg::LINK_W-1:0]     links;
    logic [btmx_pkg::LINK_W-1:0]     wdata;
    logic [btmx_pkg::NODE_W-1:0]     l0, l1, sel, want, other, new_node;
    logic                            we, b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.act <= 1'b0;
        end else begin
            stage_reg.act <= hop_in.act;
        end
        stage_reg.op    <= hop_in.op;
        stage_reg.key   <= hop_in.key;
        stage_reg.node  <= hop_in.node;
        stage_reg.fresh <= hop_in.fresh;
        stage_reg.res   <= hop_in.res;
    end

    btmx_ram #(.WIDTH(btmx_pkg::LINK_W), .DEPTH(btmx_pkg::NODE_COUNT)) u_links (
        .aclk  (aclk),
        .we    (we),
        .waddr (stage_reg.node),
        .wdata (wdata),
        .raddr (hop_in.node),
        .rdata (rdata)
    );

    // a node allocated on this walk, or an empty root, has no valid entry
    assign links    = stage_reg.fresh ? '0 : rdata;
    assign l0       = links[btmx_pkg::NODE_W-1:0];
    assign l1       = links[btmx_pkg::LINK_W-1:btmx_pkg::NODE_W];
    assign b        = stage_reg.key[btmx_pkg::KEY_BITS-1];
    assign sel      = b ? l1 : l0;
    assign want     = b ? l0 : l1;
    assign other    = sel;
    assign new_node = next_free[btmx_pkg::NODE_W-1:0];

    always_comb begin
        hop_out       = stage_reg;
        hop_out.key   = {stage_reg.key[btmx_pkg::KEY_BITS-2:0], 1'b0};
        hop_out.res   = {stage_reg.res[btmx_pkg::KEY_BITS-2:0], 1'b0};
        hop_out.fresh = 1'b0;
        we            = 1'b0;
        alloc         = 1'b0;
        wdata         = links;
        if (stage_reg.act) begin
            case (stage_reg.op)
                btmx_pkg::OP_INSERT: begin
                    if (sel == '0) begin
                        we            = 1'b1;
                        alloc         = 1'b1;
                        wdata         = b ? {new_node, l0} : {l1, new_node};
                        hop_out.node  = new_node;
                        hop_out.fresh = 1'b1;
                    end else begin
                        hop_out.node = sel;
                    end
                end
                btmx_pkg::OP_QUERY: begin
                    if (want != '0) begin
                        hop_out.res[0] = 1'b1;
                        hop_out.node   = want;
                    end else begin
                        hop_out.node = other;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/btmx_checker.sv
// Port-level checks for binary_trie_max_xor, bound to the top level.
// Depends on btmx_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module btmx_port_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [btmx_pkg::OUT_DATA_W-1:0]  m_tdata,
    input wire logic [0:0]                       m_tuser
);
    `BTMX_ASSERT_NOW(a_rej_no_xor, m_tvalid && m_tuser[0], m_tdata[btmx_pkg::KEY_BITS-1:0] == '0)
    `BTMX_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `BTMX_ASSERT_NEXT(a_word_once, m_tvalid && m_tready, !m_tvalid)
    `BTMX_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind binary_trie_max_xor btmx_port_checker u_btmx_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
